@@ design/tfp_pkg.sv @@
package tfp_pkg;

    localparam int DATA_W     = 8;
    localparam int DIST_W     = 32;
    localparam int NL_W       = 6;
    localparam int CHAR_POS_W = 5;
    localparam int LEN_W      = 9;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_SHORT     = 3'd1,
        STS_MAGIC     = 3'd2,
        STS_VERSION   = 3'd3,
        STS_ICON      = 3'd4,
        STS_NAME_LONG = 3'd5,
        STS_LENGTH    = 3'd6
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_MAGIC     = 3'd0,
        CFG_VERSION_CURRENT = 3'd1,
        CFG_VERSION_LEGACY  = 3'd2,
        CFG_ICON_LIMIT      = 3'd3,
        CFG_EXIT_LIMIT      = 3'd4
    } cfg_index_t;

    localparam logic [DATA_W-1:0] RST_FRAME_MAGIC     = 8'd0;
    localparam logic [DATA_W-1:0] RST_VERSION_CURRENT = 8'd2;
    localparam logic [DATA_W-1:0] RST_VERSION_LEGACY  = 8'd1;
    localparam logic [DATA_W-1:0] RST_ICON_LIMIT      = 8'd255;
    localparam logic [DATA_W-1:0] RST_EXIT_LIMIT      = 8'd255;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_CHECK = 2'd1,
        S_SEND  = 2'd2
    } tfp_state_t;

    typedef struct packed {
        logic [DATA_W-1:0] frame_magic;
        logic [DATA_W-1:0] version_current;
        logic [DATA_W-1:0] version_legacy;
        logic [DATA_W-1:0] icon_limit;
        logic [DATA_W-1:0] exit_limit;
    } cfg_regs_t;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] icon;
        logic [DIST_W-1:0] distance;
        logic [DATA_W-1:0] exit_id;
        logic [NL_W-1:0]   name_length;
    } frame_info_t;

    typedef struct packed {
        status_t               status;
        logic [DATA_W-1:0]     icon;
        logic [DIST_W-1:0]     distance;
        logic [DATA_W-1:0]     exit_id;
        logic [NL_W-1:0]       name_length;
        logic [DATA_W-1:0]     name_char;
        logic [CHAR_POS_W-1:0] char_position;
        logic                  char_valid;
        logic                  last_of_run;
    } result_t;

endpackage

@@ design/turn_frame_parser.sv @@
// Turn frame parser. Frame bytes enter on s_axis one per cycle while the block is idle,
// s_axis_tlast on the final byte; header fields are captured into registers and street-name
// bytes are written into a NAME_MAX-entry name RAM as they arrive. After the last byte,
// S_CHECK checks the frame; then the status item and, on success, one item per name
// character leave on m_axis, the characters read from the name RAM one per cycle while
// m_axis_tready is high. s_axis_tready stays low from the cycle after the last byte until
// the frame's final result is taken.
// Configuration writes take effect at once and are always accepted.
module turn_frame_parser
    import tfp_pkg::*;
#(
    parameter int NAME_MAX     = 32,
    parameter int HEADER_SHORT = 8,
    parameter int HEADER_LONG  = 9
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // data_byte
    input  logic                 s_axis_tlast,   // frame_end
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // status, icon, distance, exit, name_length, name_char, char_position, zero pad
    output logic [71:0]          m_axis_tdata,
    output logic                 m_axis_tuser,   // char_valid
    output logic                 m_axis_tlast,   // last_of_run
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    localparam int AW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
    localparam int CW = $clog2(NAME_MAX + 1);

    cfg_regs_t         cfg_reg;
    logic              in_accept;
    logic              clear;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    frame_info_t       info;
    result_t           result;

    assign cfg_ready = 1'b1;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_magic     <= RST_FRAME_MAGIC;
            cfg_reg.version_current <= RST_VERSION_CURRENT;
            cfg_reg.version_legacy  <= RST_VERSION_LEGACY;
            cfg_reg.icon_limit      <= RST_ICON_LIMIT;
            cfg_reg.exit_limit      <= RST_EXIT_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FRAME_MAGIC:     cfg_reg.frame_magic     <= cfg_data;
                CFG_VERSION_CURRENT: cfg_reg.version_current <= cfg_data;
                CFG_VERSION_LEGACY:  cfg_reg.version_legacy  <= cfg_data;
                CFG_ICON_LIMIT:      cfg_reg.icon_limit      <= cfg_data;
                CFG_EXIT_LIMIT:      cfg_reg.exit_limit      <= cfg_data;
                default: ;
            endcase
        end
    end

    tfp_frame_check #(
        .NAME_MAX     (NAME_MAX),
        .HEADER_SHORT (HEADER_SHORT),
        .HEADER_LONG  (HEADER_LONG),
        .AW           (AW)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (in_accept),
        .data_byte (s_axis_tdata),
        .frame_end (s_axis_tlast),
        .clear     (clear),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .info      (info)
    );

    tfp_name_ram #(
        .DEPTH (NAME_MAX),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (s_axis_tdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    tfp_emitter #(
        .AW       (AW),
        .CW       (CW)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .info      (info),
        .clear     (clear),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    assign m_axis_tdata = {2'b00, result.char_position, result.name_char, result.name_length,
                           result.exit_id, result.distance, result.icon, result.status};
    assign m_axis_tuser = result.char_valid;
    assign m_axis_tlast = result.last_of_run;

endmodule

@@ design/tfp_name_ram.sv @@
module tfp_name_ram
    import tfp_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/tfp_frame_check.sv @@
module tfp_frame_check
    import tfp_pkg::*;
#(
    parameter int NAME_MAX     = 32,
    parameter int HEADER_SHORT = 8,
    parameter int HEADER_LONG  = 9,
    parameter int AW           = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_regs_t         cfg,
    input  logic              accept,
    input  logic [DATA_W-1:0] data_byte,
    input  logic              frame_end,
    input  logic              clear,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output frame_info_t       info
);

    logic [DATA_W-1:0] byte_count_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [DATA_W-1:0] magic_reg;
    logic [DATA_W-1:0] version_reg;
    logic [DATA_W-1:0] icon_reg;
    logic [DATA_W-1:0] decl_len_reg;
    logic [DIST_W-1:0] distance_reg;
    logic [DATA_W-1:0] exit_reg;

    logic              is_current;
    logic              is_legacy;
    logic [4:0]        hdr;
    logic [DATA_W-1:0] name_off;
    logic [LEN_W-1:0]  len_expected;
    logic [DATA_W-1:0] byte_count_next;

    always_comb
    begin
        is_current = (version_reg == cfg.version_current);
        is_legacy  = (version_reg == cfg.version_legacy);
        if (is_current)
        begin
            hdr = 5'(HEADER_LONG);
        end
        else if (is_legacy)
        begin
            hdr = 5'(HEADER_SHORT);
        end
        else
        begin
            hdr = '0;
        end
    end

    // name bytes land at their offset past the header
    assign name_off = byte_count_reg - DATA_W'(hdr);
    assign wr_en    = accept && (hdr != '0) && (byte_count_reg >= DATA_W'(hdr))
                      && (name_off < DATA_W'(NAME_MAX));
    assign wr_addr  = name_off[AW-1:0];

    assign byte_count_next = (byte_count_reg == 8'd255) ? byte_count_reg
                                                        : byte_count_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            len_reg        <= '0;
            magic_reg      <= '0;
            version_reg    <= '0;
            icon_reg       <= '0;
            decl_len_reg   <= '0;
            distance_reg   <= '0;
            exit_reg       <= '0;
        end
        else if (clear)
        begin
            byte_count_reg <= '0;
            len_reg        <= '0;
            magic_reg      <= '0;
            version_reg    <= '0;
            icon_reg       <= '0;
            decl_len_reg   <= '0;
            distance_reg   <= '0;
            exit_reg       <= '0;
        end
        else if (accept)
        begin
            case (byte_count_reg)
                8'd0:    magic_reg            <= data_byte;
                8'd1:    version_reg          <= data_byte;
                8'd2:    icon_reg             <= data_byte;
                8'd3:    decl_len_reg         <= data_byte;
                8'd4:    distance_reg[7:0]    <= data_byte;
                8'd5:    distance_reg[15:8]   <= data_byte;
                8'd6:    distance_reg[23:16]  <= data_byte;
                8'd7:    distance_reg[31:24]  <= data_byte;
                8'd8:    exit_reg             <= data_byte;
                default: ;
            endcase
            byte_count_reg <= byte_count_next;
            if (frame_end)
            begin
                len_reg <= LEN_W'(byte_count_reg) + LEN_W'(1);
            end
        end
    end

    assign len_expected = LEN_W'(hdr) + LEN_W'(decl_len_reg);

    always_comb
    begin
        info = '0;
        if (len_reg < LEN_W'(HEADER_SHORT))
        begin
            info.status = STS_SHORT;
        end
        else if (magic_reg != cfg.frame_magic)
        begin
            info.status = STS_MAGIC;
        end
        else if (hdr == '0)
        begin
            info.status = STS_VERSION;
        end
        else if (len_reg < LEN_W'(hdr))
        begin
            info.status = STS_SHORT;
        end
        else if (icon_reg > cfg.icon_limit)
        begin
            info.status = STS_ICON;
        end
        else if (decl_len_reg > DATA_W'(NAME_MAX))
        begin
            info.status = STS_NAME_LONG;
        end
        else if (len_reg != len_expected)
        begin
            info.status = STS_LENGTH;
        end
        else
        begin
            info.status      = STS_OK;
            info.icon        = icon_reg;
            info.distance    = distance_reg;
            info.name_length = decl_len_reg[NL_W-1:0];
            if (is_current && (exit_reg <= cfg.exit_limit))
            begin
                info.exit_id = exit_reg;
            end
        end
    end

endmodule

@@ design/tfp_emitter.sv @@
module tfp_emitter
    import tfp_pkg::*;
#(
    parameter int AW       = 5,
    parameter int CW       = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_accept,
    input  logic              in_last,
    output logic              in_ready,
    input  frame_info_t       info,
    output logic              clear,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    input  logic [DATA_W-1:0] rd_data,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           result
);

    tfp_state_t      state_reg;
    tfp_state_t      state_next;
    result_t         result_reg;
    logic [CW-1:0]   idx_reg;
    logic [CW-1:0]   idx_inc;
    logic [NL_W-1:0] idx_wide;
    logic            load_status;
    logic            load_char;
    logic            char_is_last;

    assign idx_inc      = idx_reg + CW'(1);
    assign idx_wide     = NL_W'(idx_reg);
    assign char_is_last = (NL_W'(idx_inc) == result_reg.name_length);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        load_status = 1'b0;
        load_char   = 1'b0;
        clear       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_accept && in_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // prefetch the first name character
                load_status = 1'b1;
                clear       = 1'b1;
                rd_en       = 1'b1;
                state_next  = S_SEND;
            end
            S_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (result_reg.last_of_run)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        load_char = 1'b1;
                        if (!char_is_last)
                        begin
                            rd_en   = 1'b1;
                            rd_addr = idx_inc[AW-1:0];
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (load_status)
        begin
            idx_reg <= '0;
        end
        else if (load_char)
        begin
            idx_reg <= idx_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_status)
        begin
            result_reg.status        <= info.status;
            result_reg.icon          <= info.icon;
            result_reg.distance      <= info.distance;
            result_reg.exit_id       <= info.exit_id;
            result_reg.name_length   <= info.name_length;
            result_reg.name_char     <= '0;
            result_reg.char_position <= '0;
            result_reg.char_valid    <= 1'b0;
            result_reg.last_of_run   <= (info.status != STS_OK) || (info.name_length == '0);
        end
        else if (load_char)
        begin
            result_reg.name_char     <= rd_data;
            result_reg.char_position <= idx_wide[CHAR_POS_W-1:0];
            result_reg.char_valid    <= 1'b1;
            result_reg.last_of_run   <= char_is_last;
        end
    end

    assign result = result_reg;

endmodule

@@ tb/frame_result_checker.sv @@
module frame_result_checker
    import tfp_pkg::*;
#(
    parameter int NAME_MAX     = 32,
    parameter int HEADER_SHORT = 8,
    parameter int HEADER_LONG  = 9
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // data_byte
    input  logic                 s_axis_tlast,   // frame_end
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // status, icon, distance, exit, name_length, name_char, char_position, zero pad
    input  logic [71:0]          m_axis_tdata,
    input  logic                 m_axis_tuser,   // char_valid
    input  logic                 m_axis_tlast,   // last_of_run
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output int                   mismatches,
    output int                   outstanding,
    output int                   frames_done,
    output int                   results_seen,
    output logic [6:0]           statuses_seen
);

    cfg_regs_t   regs;
    logic [7:0]  byte_cnt;
    logic [7:0]  magic_q;
    logic [7:0]  ver_q;
    logic [7:0]  icon_q;
    logic [7:0]  nlen_q;
    logic [7:0]  exit_q;
    logic [31:0] dist_q;
    logic [7:0]  name_mem [NAME_MAX];
    result_t     turn_results_q [$];

    function automatic int hdr_bytes_for(logic [7:0] ver);
        // current version is tried first, so it wins when both match
        if (ver == regs.version_current)
            return HEADER_LONG;
        if (ver == regs.version_legacy)
            return HEADER_SHORT;
        return 0;
    endfunction

    task automatic report(string msg);
        $display("mismatch @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic clear_frame();
        byte_cnt = '0;
        magic_q  = '0;
        ver_q    = '0;
        icon_q   = '0;
        nlen_q   = '0;
        exit_q   = '0;
        dist_q   = '0;
    endtask

    task automatic absorb_byte(logic [7:0] b, logic fin);
        int      pos;
        int      hl;
        int      len;
        int      nl;
        status_t st;
        result_t r;
        pos = int'(byte_cnt);
        case (pos)
            0: magic_q = b;
            1: ver_q = b;
            2: icon_q = b;
            3: nlen_q = b;
            4: dist_q[7:0] = b;
            5: dist_q[15:8] = b;
            6: dist_q[23:16] = b;
            7: dist_q[31:24] = b;
            8: exit_q = b;
            default: ;
        endcase
        if (pos >= 2) begin
            hl = hdr_bytes_for(ver_q);
            if (hl != 0 && pos >= hl && pos - hl < NAME_MAX)
                name_mem[pos - hl] = b;
        end
        // saturate so that oversized frames count as 256 bytes
        if (byte_cnt != 8'hFF)
            byte_cnt++;
        if (!fin)
            return;

        len = pos + 1;
        hl  = hdr_bytes_for(ver_q);
        nl  = int'(nlen_q);
        if (len < HEADER_SHORT)
            st = STS_SHORT;
        else if (magic_q != regs.frame_magic)
            st = STS_MAGIC;
        else if (hl == 0)
            st = STS_VERSION;
        else if (len < hl)
            st = STS_SHORT;
        else if (icon_q > regs.icon_limit)
            st = STS_ICON;
        else if (nl > NAME_MAX)
            st = STS_NAME_LONG;
        else if (len != hl + nl)
            st = STS_LENGTH;
        else
            st = STS_OK;
        statuses_seen[st] = 1'b1;

        r = '0;
        r.status = st;
        r.last_of_run = 1'b1;
        if (st == STS_OK) begin
            r.icon        = icon_q;
            r.distance    = dist_q;
            r.exit_id     = (hl == HEADER_LONG && ver_q == regs.version_current &&
                             exit_q <= regs.exit_limit) ? exit_q : '0;
            r.name_length = nl[NL_W-1:0];
            r.last_of_run = (nl == 0);
        end
        turn_results_q.push_back(r);
        if (st == STS_OK) begin
            for (int i = 0; i < nl; i++) begin
                r.name_char     = name_mem[i];
                r.char_position = i[CHAR_POS_W-1:0];
                r.char_valid    = 1'b1;
                r.last_of_run   = (i + 1 == nl);
                turn_results_q.push_back(r);
            end
        end
        clear_frame();
        frames_done++;
    endtask

    task automatic check_result();
        result_t got;
        result_t want;
        got.status        = status_t'(m_axis_tdata[2:0]);
        got.icon          = m_axis_tdata[10:3];
        got.distance      = m_axis_tdata[42:11];
        got.exit_id       = m_axis_tdata[50:43];
        got.name_length   = m_axis_tdata[56:51];
        got.name_char     = m_axis_tdata[64:57];
        got.char_position = m_axis_tdata[69:65];
        got.char_valid    = m_axis_tuser;
        got.last_of_run   = m_axis_tlast;
        results_seen++;
        if (turn_results_q.size() == 0) begin
            report($sformatf("result item with nothing expected, tdata %h", m_axis_tdata));
            return;
        end
        want = turn_results_q.pop_front();
        if (got.status != want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.icon != want.icon)
            report($sformatf("icon %0d, expected %0d", got.icon, want.icon));
        if (got.distance != want.distance)
            report($sformatf("distance %h, expected %h", got.distance, want.distance));
        if (got.exit_id != want.exit_id)
            report($sformatf("exit %0d, expected %0d", got.exit_id, want.exit_id));
        if (got.name_length != want.name_length)
            report($sformatf("name length %0d, expected %0d", got.name_length,
                             want.name_length));
        if (got.name_char != want.name_char)
            report($sformatf("name char %h, expected %h", got.name_char, want.name_char));
        if (got.char_position != want.char_position)
            report($sformatf("char position %0d, expected %0d", got.char_position,
                             want.char_position));
        if (got.char_valid != want.char_valid)
            report($sformatf("char valid %b, expected %b", got.char_valid, want.char_valid));
        if (got.last_of_run != want.last_of_run)
            report($sformatf("last %b, expected %b", got.last_of_run, want.last_of_run));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.frame_magic     = RST_FRAME_MAGIC;
            regs.version_current = RST_VERSION_CURRENT;
            regs.version_legacy  = RST_VERSION_LEGACY;
            regs.icon_limit      = RST_ICON_LIMIT;
            regs.exit_limit      = RST_EXIT_LIMIT;
            clear_frame();
            for (int i = 0; i < NAME_MAX; i++)
                name_mem[i] = '0;
            turn_results_q.delete();
            mismatches    = 0;
            frames_done   = 0;
            results_seen  = 0;
            statuses_seen = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_FRAME_MAGIC:     regs.frame_magic     = cfg_data;
                    CFG_VERSION_CURRENT: regs.version_current = cfg_data;
                    CFG_VERSION_LEGACY:  regs.version_legacy  = cfg_data;
                    CFG_ICON_LIMIT:      regs.icon_limit      = cfg_data;
                    CFG_EXIT_LIMIT:      regs.exit_limit      = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                check_result();
        end
        outstanding = turn_results_q.size();
    end

endmodule

@@ tb/testbench.sv @@
module testbench;
    import tfp_pkg::*;

    localparam int HDR_SHORT = 8;
    localparam int HDR_LONG  = 9;

    typedef enum int {
        FK_OK_CURRENT,
        FK_OK_LEGACY,
        FK_SHORT,
        FK_MAGIC,
        FK_VERSION,
        FK_HDR_SHORT,
        FK_ICON,
        FK_NAME_LONG,
        FK_LENGTH,
        FK_NOISE
    } frame_kind_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [71:0]          m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    int         mismatches;
    int         outstanding;
    int         frames_done;
    int         results_seen;
    logic [6:0] statuses_seen;

    logic [7:0] magic_v;
    logic [7:0] cur_v;
    logic [7:0] leg_v;
    logic [7:0] icon_lim_v;
    logic [7:0] exit_lim_v;
    logic [7:0] frame_q [$];
    logic       calm;
    int         bytes_sent;

    turn_frame_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    frame_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .frames_done   (frames_done),
        .results_seen  (results_seen),
        .statuses_seen (statuses_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3000000;
        $display("status: fail");
        $finish;
    end

    // result side: random stall before every item, none while calm
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 14);
            if (gap != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
            @(negedge clk);
        end
    end

    task automatic send_frame();
        int gap;
        foreach (frame_q[i])
        begin
            gap = calm ? 0 : $urandom_range(0, 14);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= frame_q[i];
            s_axis_tlast  <= (i == frame_q.size() - 1);
            do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
            @(negedge clk);
            bytes_sent++;
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
    endtask

    task automatic set_config(logic [7:0] magic, logic [7:0] cur, logic [7:0] leg,
                              logic [7:0] icon_lim, logic [7:0] exit_lim);
        wait_drained();
        // let the output stage settle back to idle
        repeat (4) @(negedge clk);
        write_reg(CFG_FRAME_MAGIC, magic);
        write_reg(CFG_VERSION_CURRENT, cur);
        write_reg(CFG_VERSION_LEGACY, leg);
        write_reg(CFG_ICON_LIMIT, icon_lim);
        write_reg(CFG_EXIT_LIMIT, exit_lim);
        cfg_valid  <= 1'b0;
        magic_v    = magic;
        cur_v      = cur;
        leg_v      = leg;
        icon_lim_v = icon_lim;
        exit_lim_v = exit_lim;
    endtask

    task automatic run_frame(frame_kind_t kind);
        logic [7:0]  magic;
        logic [7:0]  ver;
        logic [7:0]  icon;
        logic [7:0]  nlen;
        logic [7:0]  ex;
        logic [31:0] metres;
        int          hl;
        int          total;
        calm   = ($urandom_range(0, 3) == 0);
        magic  = magic_v;
        ver    = (kind == FK_OK_LEGACY) ? leg_v : cur_v;
        icon   = 8'($urandom_range(0, icon_lim_v));
        // mostly short names, now and then up to the full store
        nlen   = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 32))
                                             : 8'($urandom_range(0, 5));
        metres = $urandom;
        ex     = 8'($urandom);
        case (kind)
            FK_MAGIC:     magic = magic_v ^ 8'($urandom_range(1, 255));
            FK_VERSION:   do ver = 8'($urandom); while (ver == cur_v || ver == leg_v);
            FK_ICON:      if (icon_lim_v != 8'hFF)
                              icon = 8'($urandom_range(icon_lim_v + 1, 255));
            FK_NAME_LONG: nlen = 8'($urandom_range(33, 255));
            default: ;
        endcase
        hl    = (ver == cur_v) ? HDR_LONG : HDR_SHORT;
        total = hl + nlen;
        case (kind)
            FK_SHORT:     total = $urandom_range(1, HDR_SHORT - 1);
            FK_HDR_SHORT: total = HDR_SHORT;
            FK_VERSION:   total = $urandom_range(HDR_SHORT, 20);
            FK_NAME_LONG: total = hl + $urandom_range(0, 8);
            FK_LENGTH:    total = (nlen != 0 && $urandom_range(0, 1)) ? total - 1
                                                                     : total + $urandom_range(1, 4);
            FK_NOISE:     total = $urandom_range(1, 12);
            default: ;
        endcase
        frame_q.delete();
        for (int i = 0; i < total; i++)
        begin
            if (kind == FK_NOISE)
                frame_q.push_back(8'($urandom));
            else
                case (i)
                    0: frame_q.push_back(magic);
                    1: frame_q.push_back(ver);
                    2: frame_q.push_back(icon);
                    3: frame_q.push_back(nlen);
                    4, 5, 6, 7: frame_q.push_back(metres[8*(i-4) +: 8]);
                    default: frame_q.push_back((i == 8 && hl == HDR_LONG) ? ex : 8'($urandom));
                endcase
        end
        send_frame();
        // hold off now and then until the block has emptied
        if ($urandom_range(0, 5) == 0)
            wait_drained();
    endtask

    task automatic random_frames(int budget);
        int          start;
        frame_kind_t kind;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            if ($urandom_range(0, 9) < 5)
                kind = $urandom_range(0, 1) ? FK_OK_CURRENT : FK_OK_LEGACY;
            else
                kind = frame_kind_t'($urandom_range(FK_SHORT, FK_NOISE));
            run_frame(kind);
        end
    endtask

    initial
    begin
        logic [7:0] shared_ver;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_FRAME_MAGIC;
        cfg_data      = '0;
        calm          = 1'b0;
        bytes_sent    = 0;
        magic_v       = RST_FRAME_MAGIC;
        cur_v         = RST_VERSION_CURRENT;
        leg_v         = RST_VERSION_LEGACY;
        icon_lim_v    = RST_ICON_LIMIT;
        exit_lim_v    = RST_EXIT_LIMIT;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single byte, wrong magic, unknown version, then a legacy frame with an empty name
        frame_q = '{8'hFF};
        send_frame();
        frame_q = '{8'hFF, cur_v, 8'h00, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78};
        send_frame();
        frame_q = '{magic_v, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame();
        frame_q = '{magic_v, leg_v, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame();

        for (int k = FK_OK_CURRENT; k <= FK_NOISE; k++)
            run_frame(frame_kind_t'(k));

        set_config(8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
        random_frames(8);

        // both versions equal: the long header wins
        shared_ver = 8'($urandom);
        set_config(8'($urandom), shared_ver, shared_ver, 8'($urandom_range(64, 200)),
                   8'($urandom));
        random_frames(8);

        set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'hFF, 8'($urandom));
        random_frames(8);

        wait_drained();
        repeat (20) @(negedge clk);
        $display("covered %0d frames (%0d bytes) over four register settings",
                 frames_done, bytes_sent);
        $display("checked %0d result items, status codes seen (6..0): %b",
                 results_seen, statuses_seen);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
